// ===== sv/upi_pkg.sv =====
// Shared types, widths and constants for the unicycle pose integrator.
// This package has no dependencies. Every other file in sv/ imports it.
package upi_pkg;

  localparam int SpeedW  = 16;  // Q8.8 speed
  localparam int TurnW   = 24;  // turn rate, angle units per second
  localparam int PosW    = 32;  // Q16.16 position
  localparam int HdgW    = 16;  // binary angle
  localparam int DtW     = 16;  // Q0.16 time step
  localparam int CfgW    = 32;  // widest config register
  localparam int CfgIdxW = 3;

  localparam int MaxSpeedW = 15;
  localparam int MaxTurnW  = 23;

  // CORDIC datapath
  localparam int CordW    = 33;  // x/y, Q2.30 with headroom
  localparam int AngW     = 22;  // z, 2^20 units per turn with headroom
  localparam int TrigW    = 16;  // Q1.15 cos/sin
  localparam int CordIter = 16;
  localparam int IterW    = 4;

  // Shared multiplier
  localparam int MulAW = 33;
  localparam int MulBW = 17;
  localparam int ProdW = MulAW + MulBW;

  localparam logic signed [CordW-1:0] CORDIC_GAIN = 33'sd652032874;

  localparam logic [MaxSpeedW-1:0] RST_MAX_SPEED = 15'd256;
  localparam logic [MaxTurnW-1:0]  RST_MAX_TURN  = 23'd65536;
  localparam logic [DtW-1:0]       RST_STEP_TIME = 16'd2621;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MAX_SPEED       = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_TURN_RATE   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_STEP_TIME       = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_INITIAL_X       = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_INITIAL_Y       = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_INITIAL_HEADING = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIG,
    ST_CV,
    ST_CVDT,
    ST_SV,
    ST_SVDT,
    ST_DONE
  } upi_state_t;

  // atan(2^-i) in units of 2^20 per turn
  function automatic logic signed [AngW-1:0] upi_atan(input logic [IterW-1:0] i);
    logic signed [AngW-1:0] r;
    case (i)
      4'd0:    r = 22'sd131072;
      4'd1:    r = 22'sd77376;
      4'd2:    r = 22'sd40884;
      4'd3:    r = 22'sd20753;
      4'd4:    r = 22'sd10417;
      4'd5:    r = 22'sd5213;
      4'd6:    r = 22'sd2607;
      4'd7:    r = 22'sd1304;
      4'd8:    r = 22'sd652;
      4'd9:    r = 22'sd326;
      4'd10:   r = 22'sd163;
      4'd11:   r = 22'sd81;
      4'd12:   r = 22'sd41;
      4'd13:   r = 22'sd20;
      4'd14:   r = 22'sd10;
      default: r = 22'sd5;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/upi_ifs.sv =====
// Valid/ready channel interfaces: command in, pose result out.
// Depends on upi_pkg for field widths.
interface upi_cmd_if;
  import upi_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [SpeedW-1:0] speed_command;
  logic signed [TurnW-1:0]  turn_rate_command;

  modport source (output valid, speed_command, turn_rate_command, input ready);
  modport sink   (input valid, speed_command, turn_rate_command, output ready);
endinterface

interface upi_pose_if;
  import upi_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [PosW-1:0]   pos_x;
  logic signed [PosW-1:0]   pos_y;
  logic [HdgW-1:0]          heading;
  logic signed [SpeedW-1:0] applied_speed;
  logic signed [TurnW-1:0]  applied_turn_rate;

  modport source (output valid, pos_x, pos_y, heading, applied_speed, applied_turn_rate,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, heading, applied_speed, applied_turn_rate,
                  output ready);
endinterface

// ===== sv/upi_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on upi_pkg for operand and product widths.
module upi_mul (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [upi_pkg::MulAW-1:0] a,
  input  logic signed [upi_pkg::MulBW-1:0] b,
  output logic signed [upi_pkg::ProdW-1:0] p
);
  import upi_pkg::*;

  logic signed [ProdW-1:0] p_q;

  always_ff @(posedge clk) begin
    if (en) begin
      p_q <= ProdW'(a) * ProdW'(b);
    end
  end

  assign p = p_q;

endmodule

// ===== sv/upi_cordic.sv =====
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, cos/sin in Q1.15.
// Depends on upi_pkg for widths, gain constant and the arctangent table.
module upi_cordic (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [upi_pkg::HdgW-1:0]        angle,
  output logic                            done,
  output logic signed [upi_pkg::TrigW-1:0] cos_val,
  output logic signed [upi_pkg::TrigW-1:0] sin_val
);
  import upi_pkg::*;

  localparam logic signed [CordW+1:0] RndHalf = (CordW+2)'(16384);
  localparam logic signed [CordW+1:0] Q15Max  = (CordW+2)'(32767);
  localparam logic signed [CordW+1:0] Q15Min  = -(CordW+2)'(32768);

  logic signed [CordW-1:0] x_q, y_q, dx, dy;
  logic signed [AngW-1:0]  z_q, z_init, atan_i;
  logic [IterW-1:0]        iter_q;
  logic                    busy_q, fin_q, neg_q, done_q, neg_init;
  logic signed [HdgW:0]    a_ext, a_fold;
  logic signed [TrigW-1:0] cos_q, sin_q;

  function automatic logic signed [TrigW-1:0] to_q15(input logic signed [CordW-1:0] v,
                                                      input logic neg);
    logic signed [CordW+1:0] t;
    logic signed [CordW+1:0] r;
    t = neg ? -(CordW+2)'(v) : (CordW+2)'(v);
    r = (t + RndHalf) >>> 15;
    if (r > Q15Max) begin
      r = Q15Max;
    end else if (r < Q15Min) begin
      r = Q15Min;
    end
    return r[TrigW-1:0];
  endfunction

  // Fold the angle into the right half plane; negate the results afterwards.
  always_comb begin
    a_ext    = (HdgW+1)'(signed'(angle));
    a_fold   = a_ext;
    neg_init = 1'b0;
    if (a_ext > (HdgW+1)'(16384)) begin
      a_fold   = a_ext - (HdgW+1)'(32768);
      neg_init = 1'b1;
    end else if (a_ext < -(HdgW+1)'(16384)) begin
      a_fold   = a_ext + (HdgW+1)'(32768);
      neg_init = 1'b1;
    end
    z_init = {{(AngW-HdgW-5){a_fold[HdgW]}}, a_fold, 4'b0000};
  end

  assign dx     = y_q >>> iter_q;
  assign dy     = x_q >>> iter_q;
  assign atan_i = upi_atan(iter_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start) begin
        x_q    <= CORDIC_GAIN;
        y_q    <= '0;
        z_q    <= z_init;
        neg_q  <= neg_init;
        iter_q <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (!z_q[AngW-1]) begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - atan_i;
        end else begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + atan_i;
        end
        iter_q <= iter_q + 1'b1;
        if (iter_q == IterW'(CordIter - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        cos_q  <= to_q15(x_q, neg_q);
        sin_q  <= to_q15(y_q, neg_q);
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign done    = done_q;
  assign cos_val = cos_q;
  assign sin_val = sin_q;

endmodule

// ===== sv/unicycle_pose_integrator_unit.sv =====
// Unicycle pose integrator top level: sequencer, config registers, pose state.
// Depends on upi_pkg, upi_ifs (upi_cmd_if, upi_pose_if), upi_mul and upi_cordic.
//
//   channel | dir | transfer payload
//   --------+-----+------------------------------------------------------------
//   cmd     | in  | speed_command, turn_rate_command
//   pose    | out | pos_x, pos_y, heading, applied_speed, applied_turn_rate
//   cfg_*   | in  | cfg_index, cfg_data, taken whenever cfg_wr_en is high
//
// After its transfer, each command goes through the trig phase (16 micro-rotations,
// rounding, and the wait for done), four passes through the shared multiplier, the write
// of the result register and the idle state that takes the next command; no new command
// is taken before that.
// The heading product w*dt runs on the multiplier while the CORDIC is busy.
// Reset is synchronous: state goes idle, config and pose take their reset values.
// A result waiting on pose.ready holds the sequencer in its final state.
module unicycle_pose_integrator_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [upi_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [upi_pkg::CfgW-1:0]      cfg_data,
  upi_cmd_if.sink                       cmd,
  upi_pose_if.source                    pose
);
  import upi_pkg::*;

  localparam logic signed [ProdW-1:0] PosRnd = ProdW'(4194304);  // 2^22
  localparam logic signed [ProdW-1:0] HdgRnd = ProdW'(32768);    // 2^15
  localparam logic signed [PosW+1:0]  PosMax = (PosW+2)'(2147483647);
  localparam logic signed [PosW+1:0]  PosMin = -(PosW+2)'(64'sd2147483648);

  // Config registers
  logic [MaxSpeedW-1:0] max_speed_q;
  logic [MaxTurnW-1:0]  max_turn_q;
  logic [DtW-1:0]       step_time_q;

  // Pose state
  logic signed [PosW-1:0] pose_x_q, pose_y_q;
  logic [HdgW-1:0]        pose_hdg_q;

  // Per-item working registers
  upi_state_t              state_q, state_next;
  logic signed [SpeedW-1:0] v_q, v_clamp, v_lim;
  logic signed [TurnW-1:0]  w_q, w_clamp, w_lim;
  logic signed [PosW-1:0]   x_new_q;
  logic [HdgW-1:0]          hdg_new_q;

  // Result register
  logic                     out_valid_q;
  logic signed [PosW-1:0]   out_x_q, out_y_q;
  logic [HdgW-1:0]          out_hdg_q;
  logic signed [SpeedW-1:0] out_v_q;
  logic signed [TurnW-1:0]  out_w_q;

  // Shared units
  logic                     cmd_ready, cmd_xfer, out_free, load_out;
  logic                     mul_en, trig_done;
  logic signed [MulAW-1:0]  mul_a;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [ProdW-1:0]  prod;
  logic signed [TrigW-1:0]  cos_val, sin_val;
  logic signed [PosW-1:0]   y_new;
  logic signed [ProdW-1:0]  hdg_sum;

  // Add a rounded Q16.16 step to a position and saturate.
  function automatic logic signed [PosW-1:0] pos_step(input logic signed [PosW-1:0] p,
                                                      input logic signed [ProdW-1:0] pr);
    logic signed [ProdW-1:0] d;
    logic signed [PosW+1:0]  s;
    d = (pr + PosRnd) >>> 23;
    s = (PosW+2)'(p) + d[PosW+1:0];
    if (s > PosMax) begin
      s = PosMax;
    end else if (s < PosMin) begin
      s = PosMin;
    end
    return s[PosW-1:0];
  endfunction

  upi_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd_xfer),
    .angle   (pose_hdg_q),
    .done    (trig_done),
    .cos_val (cos_val),
    .sin_val (sin_val)
  );

  upi_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Clamp the incoming command to the symmetric limits.
  always_comb begin
    v_lim   = SpeedW'(signed'({1'b0, max_speed_q}));
    w_lim   = TurnW'(signed'({1'b0, max_turn_q}));
    v_clamp = cmd.speed_command;
    if (cmd.speed_command > v_lim) begin
      v_clamp = v_lim;
    end else if (cmd.speed_command < -v_lim) begin
      v_clamp = -v_lim;
    end
    w_clamp = cmd.turn_rate_command;
    if (cmd.turn_rate_command > w_lim) begin
      w_clamp = w_lim;
    end else if (cmd.turn_rate_command < -w_lim) begin
      w_clamp = -w_lim;
    end
  end

  assign out_free = !out_valid_q || pose.ready;
  assign cmd_xfer = cmd.valid && cmd_ready;
  assign y_new    = pos_step(pose_y_q, prod);
  assign hdg_sum  = prod + HdgRnd;

  // Next state
  always_comb begin
    state_next = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd.valid) begin
          state_next = ST_TRIG;
        end
      end
      ST_TRIG: begin
        if (trig_done) begin
          state_next = ST_CV;
        end
      end
      ST_CV:   state_next = ST_CVDT;
      ST_CVDT: state_next = ST_SV;
      ST_SV:   state_next = ST_SVDT;
      ST_SVDT: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: multiplier operand select and handshakes
  always_comb begin
    cmd_ready = 1'b0;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    load_out  = 1'b0;
    case (state_q)
      ST_IDLE: cmd_ready = 1'b1;
      ST_TRIG: begin
        mul_en = 1'b1;
        mul_a  = MulAW'(w_q);
        mul_b  = signed'({1'b0, step_time_q});
      end
      ST_CV: begin
        mul_en = 1'b1;
        mul_a  = MulAW'(cos_val);
        mul_b  = MulBW'(v_q);
      end
      ST_CVDT, ST_SVDT: begin
        mul_en = 1'b1;
        mul_a  = signed'(prod[MulAW-1:0]);
        mul_b  = signed'({1'b0, step_time_q});
      end
      ST_SV: begin
        mul_en = 1'b1;
        mul_a  = MulAW'(sin_val);
        mul_b  = MulBW'(v_q);
      end
      ST_DONE: load_out = out_free;
      default: ;
    endcase
  end

  assign cmd.ready = cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      max_speed_q <= RST_MAX_SPEED;
      max_turn_q  <= RST_MAX_TURN;
      step_time_q <= RST_STEP_TIME;
      pose_x_q    <= '0;
      pose_y_q    <= '0;
      pose_hdg_q  <= '0;
    end else begin
      state_q <= state_next;

      // The user must issue config writes only while idle; the block itself does not
      // enforce it. A write to an initial register also loads that pose component.
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_MAX_SPEED:       max_speed_q <= cfg_data[MaxSpeedW-1:0];
          CFG_MAX_TURN_RATE:   max_turn_q  <= cfg_data[MaxTurnW-1:0];
          CFG_STEP_TIME:       step_time_q <= cfg_data[DtW-1:0];
          CFG_INITIAL_X:       pose_x_q    <= signed'(cfg_data[PosW-1:0]);
          CFG_INITIAL_Y:       pose_y_q    <= signed'(cfg_data[PosW-1:0]);
          CFG_INITIAL_HEADING: pose_hdg_q  <= cfg_data[HdgW-1:0];
          default: ;
        endcase
      end

      // Commit the new pose together with loading the result register.
      if (load_out) begin
        pose_x_q    <= x_new_q;
        pose_y_q    <= y_new;
        pose_hdg_q  <= hdg_new_q;
        out_valid_q <= 1'b1;
      end else if (pose.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working and result payload registers
  always_ff @(posedge clk) begin
    if (cmd_xfer) begin
      v_q <= v_clamp;
      w_q <= w_clamp;
    end
    // The w*dt product reaches the product register only after the trig phase starts; keep refreshing.
    if (state_q == ST_TRIG) begin
      hdg_new_q <= pose_hdg_q + hdg_sum[HdgW+15:16];
    end
    // Product register holds c*v*dt during this state.
    if (state_q == ST_SV) begin
      x_new_q <= pos_step(pose_x_q, prod);
    end
    if (load_out) begin
      out_x_q   <= x_new_q;
      out_y_q   <= y_new;
      out_hdg_q <= hdg_new_q;
      out_v_q   <= v_q;
      out_w_q   <= w_q;
    end
  end

  assign pose.valid             = out_valid_q;
  assign pose.pos_x             = out_x_q;
  assign pose.pos_y             = out_y_q;
  assign pose.heading           = out_hdg_q;
  assign pose.applied_speed     = out_v_q;
  assign pose.applied_turn_rate = out_w_q;

  // A command transfer always starts the trig phase.
  a_xfer_starts_trig: assert property (@(posedge clk) disable iff (rst)
    cmd_xfer |=> state_q == ST_TRIG)
    else $error("command transfer did not enter trig phase");

  // The CORDIC only reports completion while the sequencer waits for it.
  a_trig_done_in_trig: assert property (@(posedge clk) disable iff (rst)
    trig_done |-> state_q == ST_TRIG)
    else $error("CORDIC completion outside trig phase");

  // A new result appears only out of the final sequencer state.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("result raised outside final state");

  // No new command while the sequencer is busy with one.
  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    state_q != ST_IDLE |-> !cmd_ready)
    else $error("command ready while busy");

endmodule
